// File: sv/vertex_perspective_transform_core_macros.svh
// ----------------------------------------------------------------------------
// Vertex perspective transform assertion macros
// Shared concurrent assertion wrappers on clock and reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_PERSPECTIVE_TRANSFORM_CORE_MACROS_SVH
`define VERTEX_PERSPECTIVE_TRANSFORM_CORE_MACROS_SVH

// check a property on every clock edge outside reset
`define VPT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property on every clock edge, reset included
`define VPT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/vpt_pkg.sv
// ----------------------------------------------------------------------------
// Vertex perspective transform package
// Widths, payload types and arithmetic helpers shared by the pipeline.
// ----------------------------------------------------------------------------
package vpt_pkg;

   localparam int COORD_W         = 32;
   localparam int ENTRY_W         = 16;
   localparam int COORD_FRAC_BITS = 16;
   localparam int ENTRY_FRAC_BITS = 8;
   localparam int ROWS            = 4;
   localparam int ROW_W           = ROWS * ENTRY_W;
   localparam int PROD_W          = COORD_W + ENTRY_W;
   localparam int ACC_W           = PROD_W + 2;
   localparam int MAG_W           = ACC_W;
   localparam int DIV_STEPS       = COORD_W;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = ROW_W;

   localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
   } vertex_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      w_zero;
   } result_type;

   typedef logic [ROWS-1:0][ROW_W-1:0] matrix_type;
   typedef logic [ROWS-1:0][ACC_W-1:0] acc_vec_type;

   typedef struct packed {
      logic [MAG_W-1:0]   rem;
      logic [COORD_W-1:0] quo;
      logic               neg;
      logic               ovf;
      logic               npos;
      logic               nz;
   } lane_type;

   typedef struct packed {
      lane_type [2:0]   lane;
      logic [MAG_W-1:0] den;
      logic             w_zero;
   } div_item_type;

   function automatic logic signed [ENTRY_W-1:0] entry_of(logic [ROW_W-1:0] row, int col);
      return row[ENTRY_W*col +: ENTRY_W];
   endfunction

   function automatic logic signed [COORD_W-1:0] coord_of(vertex_type v, int k);
      logic signed [COORD_W-1:0] c;
      case (k)
         0:       c = v.in_x;
         1:       c = v.in_y;
         default: c = v.in_z;
      endcase
      return c;
   endfunction

   function automatic div_item_type div_step(div_item_type d);
      div_item_type     o;
      logic [MAG_W:0]   t;
      logic [MAG_W:0]   dd;
      o  = d;
      dd = {1'b0, d.den};
      for (int l = 0; l < 3; l++) begin
         t = {d.lane[l].rem, d.lane[l].quo[COORD_W-1]};
         if (t >= dd) begin
            o.lane[l].rem = MAG_W'(t - dd);
            o.lane[l].quo = {d.lane[l].quo[COORD_W-2:0], 1'b1};
         end else begin
            o.lane[l].rem = t[MAG_W-1:0];
            o.lane[l].quo = {d.lane[l].quo[COORD_W-2:0], 1'b0};
         end
      end
      return o;
   endfunction

   function automatic logic [COORD_W-1:0] finish_lane(lane_type l, logic w_zero);
      logic [COORD_W-1:0] r;
      if (w_zero) begin
         r = l.npos ? SAT_MAX : (l.nz ? SAT_MIN : '0);
      end else if (!l.neg) begin
         r = (l.ovf || l.quo[COORD_W-1]) ? SAT_MAX : l.quo;
      end else begin
         r = (l.ovf || l.quo > SAT_MIN) ? SAT_MIN : COORD_W'(-l.quo);
      end
      return r;
   endfunction

endpackage

// File: sv/vpt_mac.sv
// ----------------------------------------------------------------------------
// Vertex perspective transform multiply-accumulate
// Two stages: twelve coordinate-by-entry products, then the column sums.
// ----------------------------------------------------------------------------
module vpt_mac
   import vpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  vertex_type  in_data,
   input  matrix_type  matrix,
   output logic        acc_valid,
   output acc_vec_type acc
);

   logic signed [PROD_W-1:0] prod_in [3][ROWS];
   logic signed [PROD_W-1:0] prod_ff [3][ROWS];
   logic                     v1_ff;
   acc_vec_type              acc_in;
   acc_vec_type              acc_ff;
   logic                     v2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < ROWS; j++) begin
            prod_in[k][j] = coord_of(in_data, k) * entry_of(matrix[k], j);
         end
      end
   end

   always_comb begin
      for (int j = 0; j < ROWS; j++) begin
         acc_in[j] = ACC_W'(prod_ff[0][j]) + ACC_W'(prod_ff[1][j]) + ACC_W'(prod_ff[2][j])
                   + (ACC_W'(entry_of(matrix[3], j)) <<< COORD_FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

   assign acc_valid = v2_ff;
   assign acc       = acc_ff;

endmodule

// File: sv/vpt_div_pipe.sv
// ----------------------------------------------------------------------------
// Vertex perspective transform divider pipeline
// Magnitude setup, one restoring quotient bit per stage, saturating output.
// ----------------------------------------------------------------------------
`include "vertex_perspective_transform_core_macros.svh"

module vpt_div_pipe
   import vpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        acc_valid,
   input  acc_vec_type acc,
   output logic        rsp_valid,
   output result_type  rsp_data
);

   div_item_type prep_in;
   div_item_type pipe_ff  [DIV_STEPS+1];
   logic         valid_ff [DIV_STEPS+1];
   result_type   rsp_in;
   result_type   rsp_ff;
   logic         rsp_valid_ff;

   always_comb begin
      logic signed [ACC_W-1:0] den;
      logic signed [ACC_W-1:0] num;
      logic [MAG_W-1:0]        n;
      den = $signed(acc[3]);
      prep_in.den    = den[ACC_W-1] ? MAG_W'(-den) : MAG_W'(den);
      prep_in.w_zero = (den == '0);
      for (int l = 0; l < 3; l++) begin
         num = $signed(acc[l]);
         n   = num[ACC_W-1] ? MAG_W'(-num) : MAG_W'(num);
         prep_in.lane[l].rem  = n >> (COORD_W - COORD_FRAC_BITS);
         prep_in.lane[l].quo  = COORD_W'(n << COORD_FRAC_BITS);
         prep_in.lane[l].ovf  = (n >> (COORD_W - COORD_FRAC_BITS)) >= prep_in.den;
         prep_in.lane[l].neg  = num[ACC_W-1] ^ den[ACC_W-1];
         prep_in.lane[l].nz   = (num != '0);
         prep_in.lane[l].npos = !num[ACC_W-1] && (num != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STEPS; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= acc_valid;
         for (int s = 1; s <= DIV_STEPS; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff[0] <= prep_in;
         for (int s = 1; s <= DIV_STEPS; s++) begin
            pipe_ff[s] <= div_step(pipe_ff[s-1]);
         end
      end
   end

   always_comb begin
      rsp_in.out_x  = finish_lane(pipe_ff[DIV_STEPS].lane[0], pipe_ff[DIV_STEPS].w_zero);
      rsp_in.out_y  = finish_lane(pipe_ff[DIV_STEPS].lane[1], pipe_ff[DIV_STEPS].w_zero);
      rsp_in.out_z  = finish_lane(pipe_ff[DIV_STEPS].lane[2], pipe_ff[DIV_STEPS].w_zero);
      rsp_in.w_zero = pipe_ff[DIV_STEPS].w_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `VPT_ASSERT(a_last_step_lands, valid_ff[DIV_STEPS] && advance |=> rsp_valid_ff, "item lost at output stage")
   `VPT_ASSERT(a_stall_holds_out, !advance |=> $stable(rsp_ff) && $stable(rsp_valid_ff), "output changed while stalled")
   `VPT_ASSERT(a_zero_den, valid_ff[0] && pipe_ff[0].w_zero |-> pipe_ff[0].den == '0, "zero w flag with nonzero divisor")

endmodule

// File: sv/vertex_perspective_transform_core.sv
// ----------------------------------------------------------------------------
// Vertex perspective transform core
// Row vector (x, y, z, 1) times a 4x4 Q8.8 matrix, then divide by w'.
// ----------------------------------------------------------------------------
// Accepts one vertex per clock while the pipeline is not held, and returns one
// result per vertex, in order, through 36 register stages: one product stage,
// one column-sum stage, one magnitude setup stage, 32 restoring divider
// stages that each produce one quotient bit for x, y and z together, and the
// saturating output register.
// The whole pipeline holds while a result waits on rsp_ready. The matrix rows
// sit at byte addresses 0, 8, 16 and 24 of the register port and reset to
// the identity; write them only while no vertex is in flight.
module vertex_perspective_transform_core
   import vpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vertex_type            req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output result_type            rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   matrix_type  row_ff;
   logic        advance;
   logic        acc_valid;
   acc_vec_type acc;
   logic [1:0]  row_sel;

   assign row_sel = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROWS; k++) begin
            row_ff[k] <= ROW_W'(64'(1) << (ENTRY_FRAC_BITS + ENTRY_W * k));
         end
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         row_ff[row_sel] <= csr_pwdata;
      end
   end

   assign csr_prdata = row_ff[row_sel];
   assign csr_pready = 1'b1;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   vpt_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .matrix    (row_ff),
      .acc_valid (acc_valid),
      .acc       (acc)
   );

   vpt_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .acc_valid (acc_valid),
      .acc       (acc),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
